>>> rtl/core/lap3_pkg.sv
// Shared types, codes and field widths for the 3x3 Laplacian stream filter.
`default_nettype none

package lap3_pkg;

    // Pixel and window types
    typedef logic [7:0] pixel_t;
    typedef pixel_t [2:0][2:0] window_t;   // [row][col], row 0 oldest, col 0 oldest

    // Kernel selector codes; the unused code falls back to the edge kernel
    typedef enum logic [1:0] {
        FORM_EDGE     = 2'd0,
        FORM_DIAG     = 2'd1,
        FORM_WEIGHTED = 2'd2
    } kernel_form_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_KERNEL_FORM  = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_RECT_TOP     = 3'd3,
        REG_RECT_BOTTOM  = 3'd4,
        REG_RECT_LEFT    = 3'd5,
        REG_RECT_RIGHT   = 3'd6
    } cfg_reg_t;

    // Register and field widths
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int FORM_W      = 2;
    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 13;
    localparam int RECT_ROW_W  = 12;
    localparam int RECT_COL_W  = 10;
    localparam int LAP_W       = 14;
    localparam int ROW_OUT_W   = 12;
    localparam int COL_OUT_W   = 10;
    localparam int OUT_TDATA_W = 40;
    localparam int SUM_W       = 15;

    // Register reset values
    localparam logic [IMG_W_W-1:0]    IMG_W_RST  = 11'd640;
    localparam logic [IMG_H_W-1:0]    IMG_H_RST  = 13'd480;
    localparam logic [RECT_ROW_W-1:0] RECT_T_RST = 12'd1;
    localparam logic [RECT_ROW_W-1:0] RECT_B_RST = 12'd4094;
    localparam logic [RECT_COL_W-1:0] RECT_L_RST = 10'd1;
    localparam logic [RECT_COL_W-1:0] RECT_R_RST = 10'd1022;

endpackage

`default_nettype wire

>>> rtl/core/laplacian_3x3_stream_filter_core.sv
// An accepted pixel passes through the input stage and then the result register to yield its result.
// Throughput: one pixel per clock while the result side does not stall; a finished result may
// wait in the result register while the next pixel is taken in.
// The upper line store is written as the item leaves the input stage; a same-column hit is forwarded.
// Reset: control state clears at once, then a clearing pass zeroes both line stores, all MAX_WIDTH
// entries (1024 by default), with s_axis_tready low; configuration writes are taken throughout.
`default_nettype none

module laplacian_3x3_stream_filter_core
    import lap3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire                     clk,
    input  wire                     rst_n,

    // Configuration write port
    input  wire                     cfg_wr_en,
    input  wire [CFG_ADDR_W-1:0]    cfg_addr,
    input  wire [CFG_DATA_W-1:0]    cfg_wdata,

    // Pixel input
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire [7:0]               s_axis_tdata,   // [7:0] pixel
    input  wire                     s_axis_tuser,   // [0] frame_start

    // Result output
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [13:0] lap_value, [25:14] center_row,
                                                    // [35:26] center_col, [39:36] zero
    output logic                    m_axis_tlast    // frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
    localparam int HW = (RW + 1 > IMG_H_W) ? RW + 1 : IMG_H_W;
    localparam logic [WW-1:0] MaxW    = WW'(MAX_WIDTH);
    localparam logic [HW-1:0] MaxH    = HW'(MAX_HEIGHT);
    localparam logic [CW-1:0] ClrLast = CW'(MAX_WIDTH - 1);

    // Configuration registers
    kernel_form_t              form_reg;
    logic [IMG_W_W-1:0]        img_w_reg;
    logic [IMG_H_W-1:0]        img_h_reg;
    logic [RECT_ROW_W-1:0]     rect_t_reg;
    logic [RECT_ROW_W-1:0]     rect_b_reg;
    logic [RECT_COL_W-1:0]     rect_l_reg;
    logic [RECT_COL_W-1:0]     rect_r_reg;

    // Effective geometry
    logic [WW-1:0]             w_eff;
    logic [HW-1:0]             h_eff;
    logic [HW-1:0]             rlo;
    logic [HW-1:0]             rhi;
    logic [WW-1:0]             clo;
    logic [WW-1:0]             chi;

    // Position counters and clearing pass
    logic [CW-1:0]             col_cnt_reg;
    logic [CW-1:0]             col_cnt_next;
    logic [RW-1:0]             row_cnt_reg;
    logic [RW-1:0]             row_cnt_next;
    logic [CW-1:0]             clr_cnt_reg;
    logic                      clr_busy_reg;
    logic [CW-1:0]             col_base;
    logic [RW-1:0]             row_base;
    logic [CW-1:0]             col_a;
    logic [RW-1:0]             row_a;
    logic [WW-1:0]             col_inc;
    logic [HW-1:0]             row_inc;

    // Line stores
    pixel_t                    upper_mem [MAX_WIDTH];
    pixel_t                    middle_mem [MAX_WIDTH];
    pixel_t                    top_rd_reg;
    pixel_t                    mid_rd_reg;
    pixel_t                    fwd_val_reg;
    logic                      fwd_top_reg;
    pixel_t                    top_eff;

    // Input stage
    logic                      in_fire;
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic                      s1_adv;
    pixel_t                    s1_px_reg;
    logic [CW-1:0]             s1_col_reg;
    logic [RW-1:0]             s1_row_reg;

    // Window and result
    pixel_t                    win_reg [3][2];
    window_t                   win_new;
    logic [RW-1:0]             cr;
    logic [CW-1:0]             cc;
    logic                      emit;
    logic                      last_ctr;
    logic signed [LAP_W-1:0]   lap_calc;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [LAP_W-1:0]   out_lap_reg;
    logic [ROW_OUT_W-1:0]      out_row_reg;
    logic [COL_OUT_W-1:0]      out_col_reg;
    logic                      out_last_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            form_reg   <= FORM_EDGE;
            img_w_reg  <= IMG_W_RST;
            img_h_reg  <= IMG_H_RST;
            rect_t_reg <= RECT_T_RST;
            rect_b_reg <= RECT_B_RST;
            rect_l_reg <= RECT_L_RST;
            rect_r_reg <= RECT_R_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_KERNEL_FORM:  form_reg   <= kernel_form_t'(cfg_wdata[FORM_W-1:0]);
                REG_IMAGE_WIDTH:  img_w_reg  <= cfg_wdata[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: img_h_reg  <= cfg_wdata[IMG_H_W-1:0];
                REG_RECT_TOP:     rect_t_reg <= cfg_wdata[RECT_ROW_W-1:0];
                REG_RECT_BOTTOM:  rect_b_reg <= cfg_wdata[RECT_ROW_W-1:0];
                REG_RECT_LEFT:    rect_l_reg <= cfg_wdata[RECT_COL_W-1:0];
                REG_RECT_RIGHT:   rect_r_reg <= cfg_wdata[RECT_COL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the frame size and clip the rectangle
    always_comb
    begin
        priority if (WW'(img_w_reg) < WW'(3))
            w_eff = WW'(3);
        else if (WW'(img_w_reg) > MaxW)
            w_eff = MaxW;
        else
            w_eff = WW'(img_w_reg);

        priority if (HW'(img_h_reg) < HW'(3))
            h_eff = HW'(3);
        else if (HW'(img_h_reg) > MaxH)
            h_eff = MaxH;
        else
            h_eff = HW'(img_h_reg);

        rlo = (rect_t_reg == '0) ? HW'(1) : HW'(rect_t_reg);
        rhi = (HW'(rect_b_reg) > h_eff - HW'(2)) ? h_eff - HW'(2) : HW'(rect_b_reg);
        clo = (rect_l_reg == '0) ? WW'(1) : WW'(rect_l_reg);
        chi = (WW'(rect_r_reg) > w_eff - WW'(2)) ? w_eff - WW'(2) : WW'(rect_r_reg);
    end

    // Handshake of the input and result stages
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Resolve the position of the incoming pixel and advance the counters
    always_comb
    begin
        col_base = s_axis_tuser ? '0 : col_cnt_reg;
        row_base = s_axis_tuser ? '0 : row_cnt_reg;
        col_a    = (WW'(col_base) >= w_eff) ? '0 : col_base;
        row_a    = (HW'(row_base) >= h_eff) ? '0 : row_base;
        col_inc  = WW'(col_a) + WW'(1);
        row_inc  = HW'(row_a) + HW'(1);

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_fire)
        begin
            if (col_inc >= w_eff)
            begin
                col_cnt_next = '0;
                row_cnt_next = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_cnt_next = col_inc[CW-1:0];
                row_cnt_next = row_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Sweep both line stores to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + CW'(1);
            if (clr_cnt_reg == ClrLast)
                clr_busy_reg <= 1'b0;
        end
    end

    // Middle line store: read old contents and write the new pixel at the accept
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            middle_mem[clr_cnt_reg] <= '0;
        else if (in_fire)
            middle_mem[col_a] <= s_axis_tdata;
        if (in_fire)
            mid_rd_reg <= middle_mem[col_a];
    end

    // Upper line store: written as the item leaves the input stage
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            upper_mem[clr_cnt_reg] <= '0;
        else if (s1_adv)
            upper_mem[s1_col_reg] <= mid_rd_reg;
        if (in_fire)
            top_rd_reg <= upper_mem[col_a];
    end

    // Forward the upper store write that lands on the column being read
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fwd_top_reg <= s1_adv && (s1_col_reg == col_a);
            fwd_val_reg <= mid_rd_reg;
        end
    end

    assign top_eff = fwd_top_reg ? fwd_val_reg : top_rd_reg;

    // Input stage register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg  <= s_axis_tdata;
            s1_col_reg <= col_a;
            s1_row_reg <= row_a;
        end
    end

    // Form the shifted window of the item in the input stage
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_new[k][0] = win_reg[k][0];
            win_new[k][1] = win_reg[k][1];
        end
        win_new[0][2] = top_eff;
        win_new[1][2] = mid_rd_reg;
        win_new[2][2] = s1_px_reg;
    end

    // Shift the window as the item leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= '0;
                win_reg[k][1] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= win_new[k][1];
                win_reg[k][1] <= win_new[k][2];
            end
        end
    end

    lap3_kernel u_kernel
    (
        .win       (win_new),
        .form      (form_reg),
        .lap_value (lap_calc)
    );

    // Decide whether the window centre lies inside the rectangle
    always_comb
    begin
        cr       = s1_row_reg - RW'(1);
        cc       = s1_col_reg - CW'(1);
        emit     = (s1_row_reg >= RW'(2)) && (s1_col_reg >= CW'(2)) &&
                   (HW'(cr) >= rlo) && (HW'(cr) <= rhi) &&
                   (WW'(cc) >= clo) && (WW'(cc) <= chi);
        last_ctr = (HW'(cr) == rhi) && (WW'(cc) == chi);
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            out_lap_reg  <= lap_calc;
            out_row_reg  <= ROW_OUT_W'(cr);
            out_col_reg  <= COL_OUT_W'(cc);
            out_last_reg <= last_ctr;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'b0000, out_col_reg, out_row_reg, out_lap_reg};

    // A stalled item in the input stage keeps its position
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_col_reg) && $stable(s1_row_reg))
        else $error("input stage item lost or changed while stalled");

    // A new result only appears after an item left the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv))
        else $error("result appeared without an item leaving the input stage");

    // Nothing is in flight while the line stores are being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s1_valid_reg && !out_valid_reg && !s_axis_tready)
        else $error("pipeline active during line store clearing");

endmodule

`default_nettype wire

>>> rtl/core/lap3_kernel.sv
// Laplacian kernel arithmetic over one 3x3 window.
`default_nettype none

module lap3_kernel
    import lap3_pkg::*;
(
    input  wire window_t               win,
    input  wire kernel_form_t          form,
    output logic signed [LAP_W-1:0]    lap_value
);

    logic [9:0]              edge_sum;
    logic [9:0]              diag_sum;
    logic signed [SUM_W-1:0] ctr_s;
    logic signed [SUM_W-1:0] edge_s;
    logic signed [SUM_W-1:0] diag_s;
    logic signed [SUM_W-1:0] result;

    // Sum the edge and diagonal neighbors
    always_comb
    begin
        edge_sum = 10'(win[0][1]) + 10'(win[1][0]) + 10'(win[1][2]) + 10'(win[2][1]);
        diag_sum = 10'(win[0][0]) + 10'(win[0][2]) + 10'(win[2][0]) + 10'(win[2][2]);
        ctr_s    = signed'(SUM_W'(win[1][1]));
        edge_s   = signed'(SUM_W'(edge_sum));
        diag_s   = signed'(SUM_W'(diag_sum));
    end

    // Select the kernel; the unused code computes the edge form
    always_comb
    begin
        unique case (form)
            FORM_DIAG:     result = diag_s - (ctr_s <<< 2);
            FORM_WEIGHTED: result = diag_s + (edge_s <<< 2) - (ctr_s <<< 4) - (ctr_s <<< 2);
            default:       result = edge_s - (ctr_s <<< 2);
        endcase
    end

    assign lap_value = LAP_W'(result);

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the 3x3 Laplacian stream filter core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lap3_pkg::*;

    localparam int LINE_DEPTH   = 1024;
    localparam int MAX_ROWS     = 4096;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // Codes outside the defined sets, still reachable through the ports
    localparam logic [FORM_W-1:0]     FORM_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED  = 3'd7;

    typedef struct packed {
        logic signed [LAP_W-1:0] lap;
        logic [ROW_OUT_W-1:0]    row;
        logic [COL_OUT_W-1:0]    col;
        logic                    last;
    } lap_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;   // [7:0] pixel
    logic                   s_axis_tuser  = 1'b0; // [0] frame_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [13:0] lap_value, [25:14] center_row,
                                                  // [35:26] center_col, [39:36] zero
    logic                   m_axis_tlast;         // frame_done

    // Mirror of the filter state and registers
    pixel_t               upper_row [LINE_DEPTH];
    pixel_t               middle_row [LINE_DEPTH];
    window_t              win;
    int                   pos_col;
    int                   pos_row;
    logic [FORM_W-1:0]    form_reg;
    logic [IMG_W_W-1:0]   width_reg;
    logic [IMG_H_W-1:0]   height_reg;
    logic [RECT_ROW_W-1:0] top_reg;
    logic [RECT_ROW_W-1:0] bottom_reg;
    logic [RECT_COL_W-1:0] left_reg;
    logic [RECT_COL_W-1:0] right_reg;

    lap_result_t pending_results[$];
    lap_result_t want;
    lap_result_t got;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int pixels_sent     = 0;
    int results_checked = 0;
    int mismatches      = 0;

    laplacian_3x3_stream_filter_core #(
        .MAX_WIDTH  (LINE_DEPTH),
        .MAX_HEIGHT (MAX_ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Advance the filter mirror by one pixel and queue the result it causes
    function automatic void predict_laplacian(input pixel_t px, input bit fs);
        int w, h, r, c, cr, cc;
        int rlo, rhi, clo, chi;
        int ctr, edge_sum, diag_sum, v;
        pixel_t above, mid;
        lap_result_t res;
        w = (width_reg < 3) ? 3 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg);
        h = (height_reg < 3) ? 3 : (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
        if (fs)
        begin
            pos_col = 0;
            pos_row = 0;
        end
        // Wrap a position left beyond a shrunk size
        if (pos_col >= w)
            pos_col = 0;
        if (pos_row >= h)
            pos_row = 0;
        r = pos_row;
        c = pos_col;

        above         = upper_row[c];
        mid           = middle_row[c];
        upper_row[c]  = mid;
        middle_row[c] = px;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = above;
        win[1][2] = mid;
        win[2][2] = px;

        rlo = (top_reg < 1) ? 1 : int'(top_reg);
        rhi = (int'(bottom_reg) > h - 2) ? h - 2 : int'(bottom_reg);
        clo = (left_reg < 1) ? 1 : int'(left_reg);
        chi = (int'(right_reg) > w - 2) ? w - 2 : int'(right_reg);

        if (r >= 2 && c >= 2)
        begin
            cr = r - 1;
            cc = c - 1;
            if (cr >= rlo && cr <= rhi && cc >= clo && cc <= chi)
            begin
                ctr      = int'(win[1][1]);
                edge_sum = int'(win[0][1]) + int'(win[1][0]) + int'(win[1][2]) + int'(win[2][1]);
                diag_sum = int'(win[0][0]) + int'(win[0][2]) + int'(win[2][0]) + int'(win[2][2]);
                case (form_reg)
                    FORM_DIAG:     v = diag_sum - 4 * ctr;
                    FORM_WEIGHTED: v = diag_sum + 4 * edge_sum - 20 * ctr;
                    default:       v = edge_sum - 4 * ctr;
                endcase
                res.lap  = v[LAP_W-1:0];
                res.row  = cr[ROW_OUT_W-1:0];
                res.col  = cc[COL_OUT_W-1:0];
                res.last = (cr == rhi && cc == chi);
                pending_results.push_back(res);
            end
        end

        pos_col = c + 1;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // Randomly stall the result side
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Check every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.lap  = m_axis_tdata[LAP_W-1:0];
            got.row  = m_axis_tdata[LAP_W +: ROW_OUT_W];
            got.col  = m_axis_tdata[LAP_W + ROW_OUT_W +: COL_OUT_W];
            got.last = m_axis_tlast;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result lap=%0d row=%0d col=%0d last=%0b",
                                          got.lap, got.row, got.col, got.last));
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.lap !== want.lap || got.row !== want.row || got.col !== want.col ||
                    got.last !== want.last || m_axis_tdata[OUT_TDATA_W-1:36] !== '0)
                    report_mismatch($sformatf(
                        "exp lap=%0d row=%0d col=%0d last=%0b, got lap=%0d row=%0d col=%0d last=%0b pad=%h",
                        want.lap, want.row, want.col, want.last,
                        got.lap, got.row, got.col, got.last, m_axis_tdata[OUT_TDATA_W-1:36]));
            end
        end
    end

    // Offer one pixel after a random gap and hold it until the transfer
    task automatic send_pixel(input pixel_t px, input bit fs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= fs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_laplacian(px, fs);
        pixels_sent++;
    endtask

    // Hold off input until every expected result has arrived and the pipe is empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; keep the enable high when another write follows
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input bit more);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (!more)
            cfg_wr_en <= 1'b0;
        case (idx)
            REG_KERNEL_FORM:  form_reg   = val[FORM_W-1:0];
            REG_IMAGE_WIDTH:  width_reg  = val[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = val[IMG_H_W-1:0];
            REG_RECT_TOP:     top_reg    = val[RECT_ROW_W-1:0];
            REG_RECT_BOTTOM:  bottom_reg = val[RECT_ROW_W-1:0];
            REG_RECT_LEFT:    left_reg   = val[RECT_COL_W-1:0];
            REG_RECT_RIGHT:   right_reg  = val[RECT_COL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int form, input int w, input int h, input int top,
                              input int bottom, input int left, input int right);
        write_reg(REG_KERNEL_FORM, CFG_DATA_W'(form), 1'b1);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w), 1'b1);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h), 1'b1);
        write_reg(REG_RECT_TOP, CFG_DATA_W'(top), 1'b1);
        write_reg(REG_RECT_BOTTOM, CFG_DATA_W'(bottom), 1'b1);
        write_reg(REG_RECT_LEFT, CFG_DATA_W'(left), 1'b1);
        write_reg(REG_RECT_RIGHT, CFG_DATA_W'(right), 1'b0);
    endtask

    // Send a 3x3 frame: one centre value surrounded by one ring value
    task automatic send_ring_frame(input pixel_t centre, input pixel_t ring, input bit fs_first);
        for (int k = 0; k < 9; k++)
            send_pixel((k == 4) ? centre : ring, (k == 0) ? fs_first : 1'b0);
    endtask

    task automatic send_random_pixels(input int count, input bit fs_first);
        for (int k = 0; k < count; k++)
            send_pixel(pixel_t'($urandom_range(255)), (k == 0) ? fs_first : 1'b0);
    endtask

    // Extremes of each defined kernel, random data on the unused code, a frame-end wrap
    task automatic test_kernel_extremes();
        set_config(int'(FORM_WEIGHTED), 3, 3, 1, 1, 1, 1);
        send_ring_frame(8'h00, 8'hFF, 1'b1);
        send_ring_frame(8'hFF, 8'h00, 1'b0);
        wait_drained();
        write_reg(REG_KERNEL_FORM, CFG_DATA_W'(FORM_EDGE), 1'b0);
        send_ring_frame(8'hFF, 8'h00, 1'b1);
        wait_drained();
        write_reg(REG_KERNEL_FORM, CFG_DATA_W'(FORM_DIAG), 1'b0);
        send_ring_frame(8'h00, 8'hFF, 1'b1);
        wait_drained();
        write_reg(REG_KERNEL_FORM, CFG_DATA_W'(FORM_UNUSED), 1'b0);
        send_ring_frame(pixel_t'($urandom_range(255)), pixel_t'($urandom_range(255)), 1'b1);
        wait_drained();
    endtask

    // Size clamps, rectangle clipping, empty rectangle and oversized frame registers
    task automatic test_config_limits();
        write_reg(REG_UNUSED, 13'h1FFF, 1'b1);
        set_config(int'(FORM_EDGE), 0, 0, 0, 4095, 0, 1023);
        send_random_pixels(13, 1'b1);
        wait_drained();
        set_config(int'(FORM_DIAG), 4, 4, 2, 1, 1, 2);
        send_random_pixels(16, 1'b1);
        wait_drained();
        set_config(int'(FORM_WEIGHTED), 2047, 3, 1, 1, 1020, 1023);
        send_random_pixels(32, 1'b1);
        wait_drained();
        set_config(int'(FORM_EDGE), 3, 8191, 1, 4094, 1, 1022);
        send_random_pixels(30, 1'b1);
        wait_drained();
    endtask

    // Register changes while a frame is partly through
    task automatic test_midframe_changes();
        set_config(int'(FORM_EDGE), 8, 6, 1, 4, 1, 6);
        send_random_pixels(20, 1'b1);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4), 1'b0);
        send_random_pixels(10, 1'b0);
        wait_drained();
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3), 1'b0);
        send_random_pixels(10, 1'b0);
        wait_drained();
        write_reg(REG_KERNEL_FORM, CFG_DATA_W'(FORM_WEIGHTED), 1'b0);
        send_random_pixels(12, 1'b0);
        wait_drained();
    endtask

    // Mostly whole frames of random size and content, some broken or run past the end
    task automatic run_random_frames(input int idle_pct, input int stall_pct, input int n_items);
        int sent, w, h, top, bottom, left, right, n_px, stray, pause_at, swap;
        bit fs_first;
        pixel_t px;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            w      = $urandom_range(10, 3);
            h      = $urandom_range(7, 3);
            top    = $urandom_range(h - 1, 0);
            bottom = $urandom_range(h, top);
            left   = $urandom_range(w - 1, 0);
            right  = $urandom_range(w, left);
            // Empty the rectangle now and then
            if ($urandom_range(9) == 0)
            begin
                swap   = top;
                top    = bottom + 1;
                bottom = swap;
            end
            set_config($urandom_range(3), w, h, top, bottom, left, right);

            n_px     = w * h;
            fs_first = 1'b1;
            case ($urandom_range(9))
                0: n_px = $urandom_range(n_px - 1, 1);
                1: n_px = n_px + $urandom_range(2 * w, 1);
                2: fs_first = 1'b0;
                default: ;
            endcase
            stray    = ($urandom_range(9) == 0) ? int'($urandom_range(n_px - 1, 1)) : -1;
            pause_at = ($urandom_range(7) == 0) ? int'($urandom_range(n_px - 1, 1)) : -1;

            for (int k = 0; k < n_px; k++)
            begin
                if (k == pause_at)
                    wait_drained();
                if ($urandom_range(7) == 0)
                    px = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    px = pixel_t'($urandom_range(255));
                send_pixel(px, (k == 0) ? fs_first : (k == stray));
            end
            sent += n_px;
            wait_drained();
        end
    endtask

    initial
    begin
        form_reg   = FORM_EDGE;
        width_reg  = IMG_W_RST;
        height_reg = IMG_H_RST;
        top_reg    = RECT_T_RST;
        bottom_reg = RECT_B_RST;
        left_reg   = RECT_L_RST;
        right_reg  = RECT_R_RST;
        win        = '0;
        pos_col    = 0;
        pos_row    = 0;
        for (int k = 0; k < LINE_DEPTH; k++)
        begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_kernel_extremes();
        test_config_limits();
        test_midframe_changes();
        run_random_frames(0, 0, 40);
        run_random_frames(54, 0, 40);
        run_random_frames(0, 54, 40);
        run_random_frames(18, 18, 40);

        wait_drained();
        $display("Covered %0d pixel transfers and %0d checked result transfers over all kernel",
                 pixels_sent, results_checked);
        $display("selectors, size clamps, rectangle clipping, frame wrap and mid-frame changes; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("laplacian_3x3_stream_filter_core regression: pass");
        else
            $display("laplacian_3x3_stream_filter_core regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("Timeout with %0d results still expected", pending_results.size());
        $display("laplacian_3x3_stream_filter_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/lap3_pkg.sv
rtl/core/lap3_kernel.sv
rtl/core/laplacian_3x3_stream_filter_core.sv
sim/tb.sv
